FILE: design/row_window_max_binarize_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the row window max binarize core
// Shared wrappers so that every checker writes its properties the same way.
// ----------------------------------------------------------------------------
`ifndef ROW_WINDOW_MAX_BINARIZE_CORE_DEFINES_SVH
`define ROW_WINDOW_MAX_BINARIZE_CORE_DEFINES_SVH

// Property that is checked only outside of reset.
`define RWMB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property that is checked at every edge, reset included.
`define RWMB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/rwmb_pkg.sv
// ----------------------------------------------------------------------------
// rwmb_pkg
// Shared widths, reset values and payload types of the row window max
// binarize core.
// ----------------------------------------------------------------------------
`default_nettype none

package rwmb_pkg;

  localparam int MAX_RADIUS      = 64;
  localparam int MAX_ROW         = 4096;
  localparam int PIXEL_W         = 8;
  localparam int COL_W           = 12;
  localparam int RADIUS_W        = 7;
  localparam int CMD_QUEUE_DEPTH = 4;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 7'd32;

  // Input transaction: one pixel of the current row.
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               end_of_row;
  } pix_t;

  // Output transaction: one binarized column.
  typedef struct packed {
    logic             binary;
    logic [COL_W-1:0] column;
    logic             last_in_row;
  } res_t;

  // Command handed from the front end to the back end for every pixel.
  typedef struct packed {
    logic [PIXEL_W-1:0]  pixel;
    logic                end_of_row;
    logic [COL_W-1:0]    pos;
    logic [RADIUS_W-1:0] radius;
  } cmd_t;

endpackage

`default_nettype wire

FILE: design/rwmb_front.sv
// ----------------------------------------------------------------------------
// rwmb_front
// Accepts pixels, tracks the column position within the row and tags each
// pixel with the window radius in force.
// ----------------------------------------------------------------------------
`default_nettype none

module rwmb_front #(
  parameter int MAX_RADIUS = rwmb_pkg::MAX_RADIUS,
  parameter int MAX_ROW    = rwmb_pkg::MAX_ROW
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rwmb_pkg::RADIUS_W-1:0]    cfg_data,
  input  logic                             pix_valid,
  output logic                             pix_ready,
  input  rwmb_pkg::pix_t                   pix_data,
  output logic                             cmd_valid,
  input  logic                             cmd_ready,
  output rwmb_pkg::cmd_t                   cmd_data
);

  localparam int RW    = rwmb_pkg::RADIUS_W;
  localparam int CLW   = rwmb_pkg::COL_W;
  localparam int CNT_W = $clog2(MAX_ROW + 1);

  localparam logic [CNT_W-1:0] ROW_LIMIT  = CNT_W'(MAX_ROW);
  localparam logic [CNT_W-1:0] LAST_COL   = CNT_W'(MAX_ROW - 1);
  localparam logic [RW-1:0]    RADIUS_MAX = RW'(MAX_RADIUS);

  logic [RW-1:0]    radius;
  logic [RW-1:0]    radius_eff;
  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] column_count_next;
  logic [CNT_W-1:0] pos_sat;
  logic             accept;

  assign cfg_ready = 1'b1;
  assign pix_ready = cmd_ready;
  assign cmd_valid = pix_valid;
  assign accept    = pix_valid && pix_ready;

  // A radius of zero behaves as one, anything above the maximum as the maximum.
  always_comb begin
    if (radius == '0) begin
      radius_eff = RW'(1);
    end else if (radius > RADIUS_MAX) begin
      radius_eff = RADIUS_MAX;
    end else begin
      radius_eff = radius;
    end
  end

  assign pos_sat = (column_count > LAST_COL) ? LAST_COL : column_count;

  always_comb begin
    column_count_next = column_count;
    if (pix_data.end_of_row) begin
      column_count_next = '0;
    end else if (column_count < ROW_LIMIT) begin
      column_count_next = column_count + CNT_W'(1);
    end
  end

  always_comb begin
    cmd_data.pixel      = pix_data.pixel;
    cmd_data.end_of_row = pix_data.end_of_row;
    cmd_data.pos        = CLW'(pos_sat);
    cmd_data.radius     = radius_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= rwmb_pkg::RADIUS_RESET;
      column_count <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        radius <= cfg_data;
      end
      if (accept) begin
        column_count <= column_count_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/rwmb_cmd_queue.sv
// ----------------------------------------------------------------------------
// rwmb_cmd_queue
// Small command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rwmb_cmd_queue #(
  parameter int DEPTH = rwmb_pkg::CMD_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  rwmb_pkg::cmd_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output rwmb_pkg::cmd_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL      = CW'(DEPTH);

  rwmb_pkg::cmd_t slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  assign wr_ready = (count != FULL);
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/rwmb_back.sv
// ----------------------------------------------------------------------------
// rwmb_back
// Pixel history, result sequencer and pipelined window maximum with the
// binarizing compare and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rwmb_back #(
  parameter int MAX_RADIUS = rwmb_pkg::MAX_RADIUS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  rwmb_pkg::cmd_t cmd_data,
  output logic           res_valid,
  input  logic           res_ready,
  output rwmb_pkg::res_t res_data
);

  localparam int PW         = rwmb_pkg::PIXEL_W;
  localparam int CLW        = rwmb_pkg::COL_W;
  localparam int RW         = rwmb_pkg::RADIUS_W;
  localparam int HIST       = 2 * MAX_RADIUS;
  localparam int HW         = $clog2(HIST);
  localparam int DW         = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS) : 1;
  localparam int GROUP_SIZE = 8;
  localparam int NG         = (HIST + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int NG2        = (NG + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef struct packed {
    logic           valid;
    logic [DW-1:0]  d;
    logic [HW-1:0]  hi;
    logic [CLW-1:0] column;
    logic           last;
  } op_t;

  logic           adv;
  logic [PW-1:0]  hist [HIST];

  // Sequencer state.
  op_t            op;
  op_t            op_next;
  logic           flush_active;
  logic           flush_active_next;
  logic [DW-1:0]  flush_d;
  logic [DW-1:0]  flush_d_next;
  logic [CLW-1:0] flush_pos;
  logic [RW-1:0]  flush_r;
  logic           pop;

  logic [CLW-1:0] sel_pos;
  logic [RW-1:0]  sel_r;
  logic [DW-1:0]  sel_d;
  logic           sel_last;
  logic           sel_issue;
  logic [RW-1:0]  r_m1;
  logic [CLW-1:0] d_full;
  logic [CLW-1:0] reach;
  logic [CLW-1:0] hi_full;

  // Window maximum pipeline.
  logic [PW-1:0]  grp_max [NG];
  logic           a_valid;
  logic [PW-1:0]  a_gmax [NG];
  logic [PW-1:0]  a_pix;
  logic [CLW-1:0] a_column;
  logic           a_last;

  logic [PW-1:0]  blk_max [NG2];
  logic           b_valid;
  logic [PW-1:0]  b_max [NG2];
  logic [PW-1:0]  b_pix;
  logic [CLW-1:0] b_column;
  logic           b_last;

  logic [PW-1:0]  win_max;
  rwmb_pkg::res_t res_next;

  // The sequencer and the pipeline stages move together whenever the output
  // register can take a new value.
  assign adv       = !res_valid || res_ready;
  assign cmd_ready = adv && !flush_active;
  assign pop       = cmd_valid && cmd_ready;
  assign r_m1      = cmd_data.radius - RW'(1);

  always_comb begin
    sel_pos           = flush_pos;
    sel_r             = flush_r;
    sel_d             = flush_d;
    sel_last          = 1'b0;
    sel_issue         = 1'b0;
    flush_active_next = flush_active;
    flush_d_next      = flush_d;
    d_full            = '0;
    if (flush_active) begin
      sel_issue = 1'b1;
      sel_last  = (flush_d == '0);
      if (flush_d == '0) begin
        flush_active_next = 1'b0;
      end else begin
        flush_d_next = flush_d - DW'(1);
      end
    end else if (cmd_valid) begin
      sel_pos = cmd_data.pos;
      sel_r   = cmd_data.radius;
      if (cmd_data.end_of_row) begin
        // Row end: emit every outstanding column, oldest first.
        d_full    = (cmd_data.pos < CLW'(r_m1)) ? cmd_data.pos : CLW'(r_m1);
        sel_d     = d_full[DW-1:0];
        sel_issue = 1'b1;
        sel_last  = (d_full == '0);
        if (d_full != '0) begin
          flush_active_next = 1'b1;
          flush_d_next      = d_full[DW-1:0] - DW'(1);
        end
      end else begin
        sel_d     = r_m1[DW-1:0];
        sel_issue = ((CLW+1)'(cmd_data.pos) + (CLW+1)'(1)) >= (CLW+1)'(cmd_data.radius);
      end
    end
  end

  always_comb begin
    reach          = CLW'(sel_d) + CLW'(sel_r);
    hi_full        = (reach < sel_pos) ? reach : sel_pos;
    op_next.valid  = sel_issue;
    op_next.d      = sel_d;
    op_next.hi     = hi_full[HW-1:0];
    op_next.column = sel_pos - CLW'(sel_d);
    op_next.last   = sel_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op.valid     <= 1'b0;
      flush_active <= 1'b0;
    end else if (adv) begin
      op           <= op_next;
      flush_active <= flush_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flush_d <= flush_d_next;
      if (pop && cmd_data.end_of_row) begin
        flush_pos <= cmd_data.pos;
        flush_r   <= cmd_data.radius;
      end
    end
  end

  // Pixel history, newest at entry zero.
  always_ff @(posedge clk) begin
    if (pop) begin
      hist[0] <= cmd_data.pixel;
      for (int k = 1; k < HIST; k++) begin
        hist[k] <= hist[k-1];
      end
    end
  end

  // Stage A: maximum of each group of history entries inside the window.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_max[g] = '0;
      for (int i = 0; i < GROUP_SIZE; i++) begin
        if (g * GROUP_SIZE + i < HIST) begin
          if (HW'(g * GROUP_SIZE + i) <= op.hi && hist[g * GROUP_SIZE + i] > grp_max[g]) begin
            grp_max[g] = hist[g * GROUP_SIZE + i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= op.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_gmax   <= grp_max;
      a_pix    <= hist[HW'(op.d)];
      a_column <= op.column;
      a_last   <= op.last;
    end
  end

  // Stage B: maximum over blocks of group results.
  always_comb begin
    for (int j = 0; j < NG2; j++) begin
      blk_max[j] = '0;
      for (int i = 0; i < GROUP_SIZE; i++) begin
        if (j * GROUP_SIZE + i < NG) begin
          if (a_gmax[j * GROUP_SIZE + i] > blk_max[j]) begin
            blk_max[j] = a_gmax[j * GROUP_SIZE + i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_max    <= blk_max;
      b_pix    <= a_pix;
      b_column <= a_column;
      b_last   <= a_last;
    end
  end

  // Final maximum and the threshold at half of it.
  always_comb begin
    win_max = '0;
    for (int j = 0; j < NG2; j++) begin
      if (b_max[j] > win_max) begin
        win_max = b_max[j];
      end
    end
    res_next.binary      = !(b_pix < (win_max >> 1));
    res_next.column      = b_column;
    res_next.last_in_row = b_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_data <= res_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/row_window_max_binarize_core.sv
// ----------------------------------------------------------------------------
// row_window_max_binarize_core
// Adaptive binarization of a pixel stream against a sliding row maximum.
// ----------------------------------------------------------------------------
// Pixels enter on the pix channel, one column of the current row per
// transaction, with end_of_row set on the last pixel of each row. For column c
// the block compares the pixel with half the maximum of columns c-R .. c+R-1,
// clipped to the row, and sends binary, column and last_in_row on the res
// channel. The user must write the radius R on the cfg channel only while the
// block is idle; the block does not check it. Interior pixels are taken one
// per clock while the queue has room. The result for column c passes through
// the queue, sequencer, stage A, stage B and output register after column
// c+R-1 is taken. A row end makes the back end send, from the stored history,
// min(row length, R) results, one per cycle unless stalled; meanwhile the
// four-entry queue keeps accepting pixels until it fills. The window maximum
// runs through a three-stage registered tree over the 2*MAX_RADIUS entry
// history. A stalled receiver freezes the back end; results wait in the output
// register and pix_ready drops only once the queue is full. Reset clears the
// row position, the queue and all valid flags and sets the radius to 32; the
// history needs no clearing, as only pixels of the current row are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module row_window_max_binarize_core #(
  parameter int MAX_RADIUS  = rwmb_pkg::MAX_RADIUS,
  parameter int MAX_ROW     = rwmb_pkg::MAX_ROW,
  parameter int QUEUE_DEPTH = rwmb_pkg::CMD_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rwmb_pkg::RADIUS_W-1:0] cfg_data,
  input  logic                          pix_valid,
  output logic                          pix_ready,
  input  rwmb_pkg::pix_t                pix_data,
  output logic                          res_valid,
  input  logic                          res_ready,
  output rwmb_pkg::res_t                res_data
);

  // Front end to queue.
  logic           fq_valid;
  logic           fq_ready;
  rwmb_pkg::cmd_t fq_data;

  // Queue to back end.
  logic           qb_valid;
  logic           qb_ready;
  rwmb_pkg::cmd_t qb_data;

  // The front end owns the radius register and the column position. Each
  // accepted pixel becomes one command tagged with its column and radius.
  rwmb_front #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_ROW    (MAX_ROW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix_data  (pix_data),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd_data  (fq_data)
  );

  // The queue absorbs pixels that arrive while a row end is being flushed
  // or while the receiver stalls.
  rwmb_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  // The back end shifts the history, sequences the results of each command
  // and computes the windowed maximum and the threshold compare.
  rwmb_back #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd_data  (qb_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule

`default_nettype wire

FILE: design/rwmb_checker.sv
// ----------------------------------------------------------------------------
// rwmb_checker
// Port level checks of the row window max binarize core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "row_window_max_binarize_core_defines.svh"

module rwmb_checker #(
  parameter int MAX_ROW = rwmb_pkg::MAX_ROW
) (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           pix_ready,
  input wire logic           res_valid,
  input wire logic           res_ready,
  input wire rwmb_pkg::res_t res_data
);

  localparam logic [rwmb_pkg::COL_W-1:0] LAST_COL = rwmb_pkg::COL_W'(MAX_ROW - 1);

  // A stalled result transaction keeps its contents.
  `RWMB_ASSERT(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res_data), "result changed while stalled")

  // Reset empties the pipeline and the queue.
  `RWMB_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> !res_valid && pix_ready, "reset did not clear the datapath")

  // Column indices never pass the last column of the longest row.
  `RWMB_ASSERT(a_column_range, clk, rst, res_valid |-> res_data.column <= LAST_COL, "column index out of range")

  // The queue is empty right after reset, so the input side is ready.
  `RWMB_ASSERT(a_ready_after_reset, clk, rst, $fell(rst) |-> pix_ready, "input not ready after reset")

endmodule

bind row_window_max_binarize_core rwmb_checker #(
  .MAX_ROW (MAX_ROW)
) u_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_ready (pix_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_data  (res_data)
);

`default_nettype wire

FILE: dv/rwmb_binarize_sb_pkg.sv
// ----------------------------------------------------------------------------
// rwmb_binarize_sb_pkg
// Scoreboard for the row window max binarize core: predicts each binarized
// column from the accepted pixels and checks the results in order.
// ----------------------------------------------------------------------------
package rwmb_binarize_sb_pkg;

  import rwmb_pkg::*;

  localparam int HISTORY_DEPTH = 2 * MAX_RADIUS;
  localparam int REPORT_LIMIT  = 10;

  class binarize_scoreboard;

    // Newest pixel of the row sits at index 0.
    logic [PIXEL_W-1:0]  history [HISTORY_DEPTH];
    int unsigned         col_count;
    logic [RADIUS_W-1:0] radius;
    res_t                binarized_q [$];

    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned pixels_seen;
    int unsigned rows_seen;
    int unsigned radius_writes;

    function new();
      foreach (history[k]) history[k] = '0;
      col_count     = 0;
      radius        = RADIUS_RESET;
      mismatches    = 0;
      results_seen  = 0;
      pixels_seen   = 0;
      rows_seen     = 0;
      radius_writes = 0;
    endfunction

    function void set_radius(logic [RADIUS_W-1:0] value);
      radius = value;
      radius_writes++;
    endfunction

    // Zero behaves as one, anything above the maximum as the maximum.
    function int unsigned live_radius();
      if (radius == 0) return 1;
      if (radius > MAX_RADIUS) return MAX_RADIUS;
      return radius;
    endfunction

    function int unsigned outstanding();
      return binarized_q.size();
    endfunction

    // Result for the pixel d places behind the newest one, which is at column pos.
    function void predict_column(int unsigned pos, int unsigned d, int unsigned r,
                                 bit last);
      int unsigned lo;
      int unsigned hi;
      int unsigned peak;
      res_t        want;
      lo   = (d + 1 >= r) ? d + 1 - r : 0;
      hi   = d + r;
      peak = 0;
      if (hi > pos) hi = pos;
      if (hi > HISTORY_DEPTH - 1) hi = HISTORY_DEPTH - 1;
      for (int unsigned k = lo; k <= hi; k++) begin
        if (history[k] > peak) peak = history[k];
      end
      want.binary      = (history[d % HISTORY_DEPTH] < peak / 2) ? 1'b0 : 1'b1;
      want.column      = COL_W'(pos - d);
      want.last_in_row = last;
      binarized_q.push_back(want);
    endfunction

    function void note_pixel(pix_t item);
      int unsigned pos;
      int unsigned r;
      int unsigned d;
      for (int k = HISTORY_DEPTH - 1; k > 0; k--) history[k] = history[k-1];
      history[0] = item.pixel;
      pixels_seen++;
      r   = live_radius();
      pos = (col_count > MAX_ROW - 1) ? MAX_ROW - 1 : col_count;
      if (col_count < MAX_ROW) col_count++;
      if (!item.end_of_row) begin
        if (pos + 1 >= r) predict_column(pos, r - 1, r, 1'b0);
      end else begin
        // Row end: every column still waiting comes out, oldest first.
        d = (pos < r - 1) ? pos : r - 1;
        for (int i = d; i >= 0; i--) predict_column(pos, i, r, i == 0);
        col_count = 0;
        rows_seen++;
      end
    endfunction

    function void report(string why, bit have_want, res_t want, res_t got);
      mismatches++;
      if (mismatches > REPORT_LIMIT) return;
      if (have_want)
        $display("ERROR: %s: expected binary=%0d column=%0d last=%0d, got binary=%0d column=%0d last=%0d",
                 why, want.binary, want.column, want.last_in_row,
                 got.binary, got.column, got.last_in_row);
      else
        $display("ERROR: %s: got binary=%0d column=%0d last=%0d",
                 why, got.binary, got.column, got.last_in_row);
    endfunction

    function void check_result(res_t got);
      res_t want;
      results_seen++;
      if (binarized_q.size() == 0) begin
        report("result with nothing outstanding", 1'b0, '0, got);
        return;
      end
      want = binarized_q.pop_front();
      if (got.binary !== want.binary || got.column !== want.column ||
          got.last_in_row !== want.last_in_row)
        report("result differs", 1'b1, want, got);
    endfunction

  endclass

endpackage

FILE: dv/tb_row_window_max_binarize_core.sv
// ----------------------------------------------------------------------------
// tb_row_window_max_binarize_core
// Self-checking bench for the row window max binarize core.
// ----------------------------------------------------------------------------
// Pixels are pushed through the pix channel in rows, the radius register is
// rewritten between phases, and every result on the res channel is compared
// field by field with a scoreboard that predicts the binarized columns from
// the accepted pixel transactions. Both channels see random idle cycles,
// apart from one long stretch where data flows without a gap.
// ----------------------------------------------------------------------------
module tb_row_window_max_binarize_core;

  import rwmb_pkg::*;
  import rwmb_binarize_sb_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_PIXELS = 96;
  localparam int STEADY_PIXELS = 40;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [RADIUS_W-1:0] cfg_data;
  logic                pix_valid;
  logic                pix_ready;
  pix_t                pix_data;
  logic                res_valid;
  logic                res_ready;
  res_t                res_data;

  // When set, neither the pixel sender nor the result receiver idles.
  bit          steady = 1'b0;
  int unsigned cycle_count = 0;

  binarize_scoreboard sb;

  row_window_max_binarize_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix_data  (pix_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still outstanding",
               cycle_count, sb.outstanding());
      $display("Mismatches found");
      $finish;
    end
  end

  // The receiver stalls with a probability of roughly 16 percent unless the
  // steady stretch is running.
  always @(posedge clk) begin
    res_ready <= steady || ($urandom_range(0, 99) >= 16);
  end

  // Monitors sample at the rising edge, so they see the same values the core
  // does when it decides that a transaction has happened.
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) sb.set_radius(cfg_data);
    if (!rst && pix_valid && pix_ready) sb.note_pixel(pix_data);
    if (!rst && res_valid && res_ready) sb.check_result(res_data);
  end

  // Offers one pixel and returns at the edge where it is taken. Valid is left
  // high so that back-to-back pixels need no extra assignment.
  task automatic send_pixel(input logic [PIXEL_W-1:0] value, input logic eor);
    while (!steady && $urandom_range(0, 99) < 16) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix_data  <= '{pixel: value, end_of_row: eor};
    @(posedge clk);
    while (!pix_ready) @(posedge clk);
  endtask

  // Holds the sender off until every predicted result has come back, then
  // lets the pipeline run dry, since pixels early in a row give no result.
  task automatic drain_results();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_radius(input logic [RADIUS_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A few pixel textures: flat random, dark rows with rare highlights, and
  // mid-gray rows where many pixels sit close to half of the window peak.
  function automatic logic [PIXEL_W-1:0] pick_pixel(int unsigned texture);
    case (texture)
      0: begin
        return PIXEL_W'($urandom_range(0, 255));
      end
      1: begin
        if ($urandom_range(0, 9) == 0) return 8'd255;
        return PIXEL_W'($urandom_range(0, 40));
      end
      default: begin
        return PIXEL_W'($urandom_range(50, 140));
      end
    endcase
  endfunction

  task automatic send_row(input int unsigned len, input bit close_row);
    int unsigned texture;
    texture = $urandom_range(0, 2);
    for (int unsigned i = 0; i < len; i++)
      send_pixel(pick_pixel(texture), close_row && (i == len - 1));
  endtask

  initial begin
    int unsigned random_sent;
    int unsigned row_len;
    int unsigned rows_since_write;

    sb = new();
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    pix_valid <= 1'b0;
    pix_data  <= '0;
    res_ready <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset radius of 32: a three-pixel row is shorter than the window, so it
    // yields nothing until its end. Then a row of a single pixel.
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0,   1'b0);
    send_pixel(8'd127, 1'b1);
    send_pixel(8'd0,   1'b1);

    // Smallest radius: every pixel completes its own window.
    // The 128 pixel sits just above half of the 255 peak beside it.
    write_radius(7'd1);
    send_pixel(8'd0,   1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd127, 1'b1);

    // A radius of zero must behave as one.
    write_radius(7'd0);
    send_pixel(8'd10, 1'b0);
    send_pixel(8'd21, 1'b1);

    // The largest code behaves as the maximum radius.
    write_radius(7'd127);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd99,  1'b0);
    send_pixel(8'd100, 1'b0);
    send_pixel(8'd255, 1'b1);

    write_radius(MAX_RADIUS[RADIUS_W-1:0]);
    send_pixel(8'd1,   1'b0);
    send_pixel(8'd254, 1'b1);

    // Radius changed in the middle of a row: some columns are reported twice.
    write_radius(7'd3);
    send_pixel(8'd40,  1'b0);
    send_pixel(8'd90,  1'b0);
    send_pixel(8'd30,  1'b0);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd101, 1'b0);
    write_radius(7'd5);
    send_pixel(8'd0,   1'b0);
    send_pixel(8'd60,  1'b0);
    send_pixel(8'd255, 1'b1);

    // One row that runs without any idle cycle on either side.
    write_radius(7'd2);
    steady = 1'b1;
    for (int unsigned i = 0; i < STEADY_PIXELS; i++) begin
      send_pixel(pick_pixel(0), i == STEADY_PIXELS - 1);
    end
    steady = 1'b0;

    // Random rows, mostly short so that row ends and flushes come often, with
    // the radius rewritten every few rows, usually to a small value.
    random_sent      = 0;
    rows_since_write = 0;
    while (random_sent < RANDOM_PIXELS) begin
      if (rows_since_write >= $urandom_range(1, 3)) begin
        if ($urandom_range(0, 3) == 0)
          write_radius(RADIUS_W'($urandom_range(0, 127)));
        else
          write_radius(RADIUS_W'($urandom_range(1, 8)));
        rows_since_write = 0;
      end
      if ($urandom_range(0, 3) == 0) row_len = $urandom_range(30, 90);
      else row_len = $urandom_range(1, 16);
      if (row_len > RANDOM_PIXELS - random_sent) row_len = RANDOM_PIXELS - random_sent;
      send_row(row_len, 1'b1);
      random_sent += row_len;
      rows_since_write++;
    end

    // Final wait: everything predicted must arrive, and nothing may follow.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d pixels in %0d rows, %0d results, %0d radius writes.",
             sb.pixels_seen, sb.rows_seen, sb.results_seen, sb.radius_writes);
    $display("Included short rows, radius codes 0, 1, 64 and 127, a mid-row radius change and a gap-free row.");
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d errors, %0d results missing", sb.mismatches, sb.outstanding());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
